### hw/rtl/itoa_pkg.sv
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int DIGITS    = 20;
  localparam int VALUE_W   = 64;
  localparam int WIDTH_W   = 7;
  localparam int DCNT_W    = 5;
  localparam int STEP_W    = 5;
  localparam int IN_DATA_W = 72;
  localparam int IN_USER_W = 3;
  localparam int CHAR_W    = 8;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LOWER = 8'h61;

  localparam logic [STEP_W-1:0] LAST_STEP = 5'd31;

  typedef logic [DIGITS-1:0][3:0] digits_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_MEASURE,
    S_SIGN,
    S_PAD,
    S_DIGITS
  } state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_SIGN,
    EMIT_PAD,
    EMIT_DIGIT
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  convert;
    logic  measure;
    emit_t emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic neg;
    logic zero_pad;
    logic pad_zero;
    logic pad_one;
    logic digit_one;
    logic out_free;
  } dp_status_t;

  function automatic logic [CHAR_W-1:0] digit_char(logic [3:0] d, logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_UPPER : CH_LOWER;
    if (d < 4'd10) begin
      return CH_ZERO + {4'b0, d};
    end
    return base + {4'b0, d} - 8'd10;
  endfunction

endpackage

### hw/rtl/itoa_ctrl.sv
`timescale 1ns / 1ps

module itoa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  itoa_pkg::dp_status_t status,
  output itoa_pkg::ctrl_cmd_t  cmd
);
  import itoa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (status.conv_done) begin
          state_nxt = S_MEASURE;
        end
      end
      S_MEASURE: begin
        state_nxt = status.zero_pad ? S_SIGN : S_PAD;
      end
      S_SIGN: begin
        if (!status.neg || status.out_free) begin
          state_nxt = status.zero_pad ? S_PAD : S_DIGITS;
        end
      end
      S_PAD: begin
        if (status.pad_zero || (status.out_free && status.pad_one)) begin
          state_nxt = status.zero_pad ? S_DIGITS : S_SIGN;
        end
      end
      S_DIGITS: begin
        if (status.out_free && status.digit_one) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.load    = 1'b0;
    cmd.convert = 1'b0;
    cmd.measure = 1'b0;
    cmd.emit    = EMIT_NONE;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      S_CONV: begin
        cmd.convert = 1'b1;
      end
      S_MEASURE: begin
        cmd.measure = 1'b1;
      end
      S_SIGN: begin
        if (status.neg && status.out_free) begin
          cmd.emit = EMIT_SIGN;
        end
      end
      S_PAD: begin
        if (!status.pad_zero && status.out_free) begin
          cmd.emit = EMIT_PAD;
        end
      end
      S_DIGITS: begin
        if (status.out_free) begin
          cmd.emit = EMIT_DIGIT;
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

### hw/rtl/itoa_datapath.sv
`timescale 1ns / 1ps

module itoa_datapath #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [itoa_pkg::IN_DATA_W-1:0]        in_tdata,
  input  logic [itoa_pkg::IN_USER_W-1:0]        in_tuser,
  input  itoa_pkg::ctrl_cmd_t                   cmd,
  output itoa_pkg::dp_status_t                  status,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [itoa_pkg::CHAR_W-1:0]           out_tdata,
  output logic                                  out_tlast
);
  import itoa_pkg::*;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX = WIDTH_W'(MAX_WIDTH);

  logic [VALUE_W-1:0] value_in;
  logic               hex_in;
  logic               neg_in;
  logic [VALUE_W-1:0] mag_in;
  digits_t            hex_digits;

  logic               hex_r, upper_r, zero_r, neg_r;
  logic [WIDTH_W-1:0] width_r;
  logic [VALUE_W-1:0] mag_r;
  digits_t            bcd_r;
  logic [STEP_W-1:0]  step_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [WIDTH_W-1:0] pad_r;

  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;

  logic [DCNT_W-1:0]  lead;
  logic [WIDTH_W-1:0] width_sat;
  logic [WIDTH_W-1:0] body;
  logic [WIDTH_W-1:0] pad_calc;
  logic               out_free;
  logic               emit_go;
  logic [CHAR_W-1:0]  char_nxt;
  logic [3:0]         cur_digit;

  function automatic digits_t dabble(digits_t b, logic bit_in);
    digits_t            t;
    logic [DIGITS*4-1:0] flat;
    for (int i = 0; i < DIGITS; i++) begin
      t[i] = (b[i] >= 4'd5) ? b[i] + 4'd3 : b[i];
    end
    flat = t;
    return digits_t'({flat[DIGITS*4-2:0], bit_in});
  endfunction

  assign value_in = in_tdata[VALUE_W-1:0];
  assign hex_in   = in_tuser[0];
  assign neg_in   = !hex_in && value_in[VALUE_W-1];
  assign mag_in   = neg_in ? (~value_in + 64'd1) : value_in;

  always_comb begin
    hex_digits = '0;
    for (int i = 0; i < VALUE_W / 4; i++) begin
      hex_digits[i] = value_in[4*i +: 4];
    end
  end

  always_comb begin
    lead = 5'd1;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) begin
        lead = DCNT_W'(i + 1);
      end
    end
  end

  assign width_sat = (width_r > WIDTH_MAX) ? WIDTH_MAX : width_r;
  assign body      = {2'b00, lead} + {6'b0, neg_r};
  assign pad_calc  = (width_sat > body) ? width_sat - body : '0;

  assign out_free  = !out_valid_r || out_tready;
  assign emit_go   = (cmd.emit != EMIT_NONE);
  assign cur_digit = bcd_r[dcnt_r - 5'd1];

  always_comb begin
    unique case (cmd.emit)
      EMIT_SIGN:  char_nxt = CH_MINUS;
      EMIT_PAD:   char_nxt = zero_r ? CH_ZERO : CH_SPACE;
      EMIT_DIGIT: char_nxt = digit_char(cur_digit, upper_r);
      default:    char_nxt = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hex_r   <= hex_in;
      upper_r <= in_tuser[1];
      zero_r  <= in_tuser[2];
      neg_r   <= neg_in;
      width_r <= in_tdata[VALUE_W +: WIDTH_W];
      mag_r   <= mag_in;
      bcd_r   <= hex_in ? hex_digits : '0;
      step_r  <= '0;
    end else if (cmd.convert && !hex_r) begin
      bcd_r  <= dabble(dabble(bcd_r, mag_r[VALUE_W-1]), mag_r[VALUE_W-2]);
      mag_r  <= {mag_r[VALUE_W-3:0], 2'b00};
      step_r <= step_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r      <= '0;
      pad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.measure) begin
        dcnt_r <= lead;
        pad_r  <= pad_calc;
      end else if (cmd.emit == EMIT_PAD) begin
        pad_r <= pad_r - 7'd1;
      end else if (cmd.emit == EMIT_DIGIT) begin
        dcnt_r <= dcnt_r - 5'd1;
      end
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_char_r <= char_nxt;
      out_last_r <= (cmd.emit == EMIT_DIGIT) && (dcnt_r == 5'd1);
    end
  end

  assign status.conv_done = hex_r || (step_r == LAST_STEP);
  assign status.neg       = neg_r;
  assign status.zero_pad  = zero_r;
  assign status.pad_zero  = (pad_r == '0);
  assign status.pad_one   = (pad_r == 7'd1);
  assign status.digit_one = (dcnt_r == 5'd1);
  assign status.out_free  = out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

### hw/rtl/integer_to_ascii_padded.sv
`timescale 1ns / 1ps
// Formats one 64-bit value per input item as ASCII text, one character per output item.
// The input channel carries the value and minimum field width in in_tdata and the
// hex, upper-case and zero-pad flags in in_tuser. The output channel carries one
// character in out_tdata, most significant first, with out_tlast on the final one.
// An item is accepted only while the block is idle. Decimal items pass through a
// binary-to-BCD converter that shifts two bits of magnitude per cycle; hex items
// load their digits directly and skip the conversion. The measure state then finds the
// digit count and the pad count. Characters leave at most one per cycle through a single
// output register, while the receiver takes them.
// When the receiver holds out_tready low, the output register keeps its character
// and the sequencer waits; nothing is dropped.
// Reset (rst_n low at a clock edge) returns the sequencer to idle and empties the
// output register; the first item can be accepted as soon as rst_n is high again.

module integer_to_ascii_padded #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // Fields from bit 0: value[63:0], min_width[70:64], bit 71 unused.
  input  logic [itoa_pkg::IN_DATA_W-1:0] in_tdata,
  // Fields from bit 0: hex_mode, upper_case, zero_pad.
  input  logic [itoa_pkg::IN_USER_W-1:0] in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // Fields from bit 0: char_code[7:0].
  output logic [itoa_pkg::CHAR_W-1:0]    out_tdata,
  output logic                           out_tlast
);
  import itoa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  itoa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  itoa_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### bench/integer_to_ascii_padded_tb.sv
`timescale 1ns / 1ps

module integer_to_ascii_padded_tb;
  import itoa_pkg::*;

  localparam int MAX_WIDTH = 64;
  localparam int MAX_DIGITS = 20;

  class text_scoreboard;
    typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
    } char_item_t;

    char_item_t expected_chars[$];
    int         errors = 0;
    int         chars_seen = 0;

    task report(string msg);
      errors++;
      if (errors <= 50) begin
        $display("ERROR at %0t ns: %s", $time, msg);
      end
    endtask

    function int pending();
      return expected_chars.size();
    endfunction

    function void note_item(logic [VALUE_W-1:0] value, logic hex, logic upper,
                            logic [WIDTH_W-1:0] width, logic zero);
      logic [3:0]        digits[MAX_DIGITS];
      logic [VALUE_W-1:0] mag;
      logic [CHAR_W-1:0] line[$];
      logic [CHAR_W-1:0] ch;
      logic              neg;
      int                ndig;
      int                body;
      int                pad;
      int                field;
      char_item_t        item;
      field = (width > MAX_WIDTH) ? MAX_WIDTH : int'(width);
      neg = !hex && value[VALUE_W-1];
      mag = neg ? (~value + 64'd1) : value;
      ndig = 0;
      do begin
        if (hex) begin
          digits[ndig] = mag[3:0];
          mag = mag >> 4;
        end else begin
          digits[ndig] = 4'(mag % 64'd10);
          mag = mag / 64'd10;
        end
        ndig++;
      end while (mag != 0 && ndig < MAX_DIGITS);
      body = ndig + (neg ? 1 : 0);
      pad = (field > body) ? field - body : 0;
      if (zero) begin
        if (neg) line.push_back(CH_MINUS);
        repeat (pad) line.push_back(CH_ZERO);
      end else begin
        repeat (pad) line.push_back(CH_SPACE);
        if (neg) line.push_back(CH_MINUS);
      end
      for (int i = ndig - 1; i >= 0; i--) begin
        if (digits[i] < 4'd10) begin
          ch = CH_ZERO + {4'b0, digits[i]};
        end else begin
          ch = (upper ? CH_UPPER : CH_LOWER) + {4'b0, digits[i]} - 8'd10;
        end
        line.push_back(ch);
      end
      while (line.size() > MAX_WIDTH) void'(line.pop_back());
      foreach (line[i]) begin
        item.code = line[i];
        item.last = (i == line.size() - 1);
        expected_chars.push_back(item);
      end
    endfunction

    task check_char(logic [CHAR_W-1:0] code, logic last);
      char_item_t want;
      chars_seen++;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected character 0x%02h last=%0b", code, last));
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.code) begin
        report($sformatf("character %0d: got 0x%02h, expected 0x%02h",
                         chars_seen, code, want.code));
      end
      if (last !== want.last) begin
        report($sformatf("character %0d: tlast got %0b, expected %0b",
                         chars_seen, last, want.last));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic [IN_USER_W-1:0]   in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [CHAR_W-1:0]      out_tdata;
  logic                   out_tlast;

  text_scoreboard sb = new;
  bit calm = 1'b0;
  int hold_len = 0;

  integer_to_ascii_padded #(
    .MAX_WIDTH(MAX_WIDTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_char(out_tdata, out_tlast);
    end
  end

  initial begin
    int n;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_number(input logic [VALUE_W-1:0] value, input logic hex,
                             input logic upper, input logic [WIDTH_W-1:0] width,
                             input logic zero);
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, width, value};
    in_tuser <= {zero, upper, hex};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(value, hex, upper, width, zero);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = 64'($urandom_range(0, 999));
      1: begin
        v = 64'd1;
        repeat ($urandom_range(0, 19)) v = v * 64'd10;
        v = v + 64'($urandom_range(0, 2)) - 64'd1;
      end
      2: begin
        case ($urandom_range(0, 4))
          0: v = '0;
          1: v = 64'd1;
          2: v = '1;
          3: v = 64'h7fff_ffff_ffff_ffff;
          default: v = 64'h8000_0000_0000_0000;
        endcase
      end
      3: v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    if ($urandom_range(0, 1) == 1) v = ~v + 64'd1;
    return v;
  endfunction

  function automatic logic [WIDTH_W-1:0] pick_width();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(0, 24));
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_number(64'd0, 1'b0, 1'b0, 7'd0, 1'b0);
    send_number(64'd0, 1'b1, 1'b1, 7'd5, 1'b1);
    send_number('1, 1'b0, 1'b0, 7'd0, 1'b0);
    send_number(64'h7fff_ffff_ffff_ffff, 1'b0, 1'b1, 7'd0, 1'b0);
    send_number(64'h8000_0000_0000_0000, 1'b0, 1'b0, 7'd0, 1'b0);
    send_number(64'h8000_0000_0000_0000, 1'b0, 1'b0, 7'd25, 1'b1);
    send_number(64'h8000_0000_0000_0000, 1'b0, 1'b0, 7'd25, 1'b0);
    send_number(64'h8000_0000_0000_0000, 1'b1, 1'b1, 7'd0, 1'b0);
    send_number('1, 1'b1, 1'b0, 7'd20, 1'b1);
    send_number(64'h0123_4567_89ab_cdef, 1'b1, 1'b1, 7'd0, 1'b0);
    send_number(64'h0123_4567_89ab_cdef, 1'b1, 1'b0, 7'd18, 1'b0);
    send_number(64'hfedc_ba98_7654_3210, 1'b1, 1'b0, 7'd16, 1'b1);
    send_number(-64'sd42, 1'b0, 1'b0, 7'd10, 1'b1);
    send_number(-64'sd42, 1'b0, 1'b1, 7'd10, 1'b0);
    send_number(64'd42, 1'b0, 1'b0, 7'd64, 1'b1);
    send_number(64'd7, 1'b0, 1'b0, 7'd127, 1'b1);
    send_number(-64'sd7, 1'b0, 1'b0, 7'd65, 1'b0);
    send_number(64'habc, 1'b1, 1'b1, 7'd100, 1'b0);
    send_number(64'd12345, 1'b0, 1'b0, 7'd3, 1'b1);
    send_number(-64'sd12345, 1'b0, 1'b0, 7'd6, 1'b0);
    send_number(64'd9, 1'b0, 1'b0, 7'd1, 1'b1);
    send_number(64'd1_000_000_000_000_000_000, 1'b0, 1'b0, 7'd0, 1'b0);

    hold_len = 300;
    repeat (4) send_number(pick_value(), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), pick_width(),
                           1'($urandom_range(0, 1)));
    in_tvalid <= 1'b0;
    wait_drained();

    for (int i = 0; i < 380; i++) begin
      if (i == 320) calm = 1'b1;
      if (i == 150) begin
        in_tvalid <= 1'b0;
        wait_drained();
      end
      send_number(pick_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  pick_width(), 1'($urandom_range(0, 1)));
    end
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
